// File: design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// Temperature channel plausibility package
// Shared types and constants: fault codes, register indexes, item, result,
// per-channel state and configuration bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 2'd2;

    localparam logic [11:0] OPEN_CODE_RESET  = 12'd4095;
    localparam logic [11:0] SHORT_CODE_RESET = 12'd0;
    localparam logic [15:0] RATE_LIMIT_RESET = 16'd65535;

    // Milliseconds per second, used to cross-multiply the rate test.
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_OPEN  = 2'd1,
        FAULT_SHORT = 2'd2,
        FAULT_RATE  = 2'd3
    } t_fault;

    typedef struct packed {
        logic [11:0] open_code;
        logic [11:0] short_code;
        logic [15:0] rate_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         channel;
        logic [11:0]        adc_code;
        logic signed [15:0] temperature;
        logic [31:0]        time_ms;
    } t_item;

    typedef struct packed {
        t_fault             fault;
        logic               valid;
        logic               primed;
        logic signed [15:0] last_temperature;
        logic [31:0]        last_time;
    } t_chan_state;

    typedef struct packed {
        logic [2:0]         out_channel;
        t_fault             fault_code;
        logic               reading_valid;
        logic signed [15:0] held_temperature;
    } t_result;

endpackage

`default_nettype wire

// File: design/tcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the open and short thresholds and the rate limit, written through a
// plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tcp_pkg::t_cfg                       o_cfg
);
    import tcp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_code  <= OPEN_CODE_RESET;
            r_cfg.short_code <= SHORT_CODE_RESET;
            r_cfg.rate_limit <= RATE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OPEN_CODE:  r_cfg.open_code  <= i_cfg_data[11:0];
                CFG_SHORT_CODE: r_cfg.short_code <= i_cfg_data[11:0];
                CFG_RATE_LIMIT: r_cfg.rate_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/tcp_eval.sv
// ----------------------------------------------------------------------------
// Channel evaluation
// Combinational check of one sample against the state of its channel: sensor
// fault decode, rate test and the updated channel state.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_eval #(
    parameter  int REJECT_LIMIT = 3,
    localparam int RcW          = $clog2(REJECT_LIMIT + 1)
) (
    input  wire tcp_pkg::t_cfg        i_cfg,
    input  wire tcp_pkg::t_item       i_item,
    input  wire tcp_pkg::t_chan_state i_state,
    input  wire logic [RcW-1:0]       i_rej_cnt,
    output tcp_pkg::t_chan_state      o_state,
    output logic [RcW-1:0]            o_rej_cnt,
    output tcp_pkg::t_result          o_result
);
    import tcp_pkg::*;

    t_fault             sensor_fault;
    logic [31:0]        dt;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [26:0]        lhs;
    logic [47:0]        rhs;
    logic               rate_exceeded;
    logic [RcW-1:0]     cnt_inc;

    // Open wins over short; a latched rate fault survives a good code.
    always_comb begin
        if (i_item.adc_code >= i_cfg.open_code) begin
            sensor_fault = FAULT_OPEN;
        end else if (i_item.adc_code <= i_cfg.short_code) begin
            sensor_fault = FAULT_SHORT;
        end else if (i_state.fault == FAULT_RATE) begin
            sensor_fault = FAULT_RATE;
        end else begin
            sensor_fault = FAULT_OK;
        end
    end

    // Change rate test, cross-multiplied: |dT| * 1000 > limit * dt.
    assign dt   = i_item.time_ms - i_state.last_time;
    assign diff = $signed({i_item.temperature[15], i_item.temperature})
                - $signed({i_state.last_temperature[15], i_state.last_temperature});
    assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
    assign lhs  = 27'(mag) * 27'(MS_PER_S);
    assign rhs  = 48'(i_cfg.rate_limit) * 48'(dt);
    assign rate_exceeded = i_state.primed && (dt != 32'd0) && (48'(lhs) > rhs);

    assign cnt_inc = (i_rej_cnt < RcW'(REJECT_LIMIT)) ? RcW'(i_rej_cnt + 1'b1) : i_rej_cnt;

    always_comb begin
        o_state       = i_state;
        o_rej_cnt     = i_rej_cnt;
        o_state.fault = sensor_fault;
        if (sensor_fault != FAULT_OK) begin
            o_state.valid = 1'b0;
        end else if (rate_exceeded) begin
            o_rej_cnt     = cnt_inc;
            o_state.valid = 1'b0;
            if (cnt_inc >= RcW'(REJECT_LIMIT)) begin
                o_state.fault = FAULT_RATE;
            end
        end else begin
            o_rej_cnt                = '0;
            o_state.last_temperature = i_item.temperature;
            o_state.last_time        = i_item.time_ms;
            o_state.valid            = 1'b1;
            o_state.primed           = 1'b1;
        end
    end

    assign o_result.out_channel      = i_item.channel;
    assign o_result.fault_code       = o_state.fault;
    assign o_result.reading_valid    = o_state.valid;
    assign o_result.held_temperature = o_state.last_temperature;

endmodule

`default_nettype wire

// File: design/temperature_channel_plausibility_core.sv
// ----------------------------------------------------------------------------
// Temperature channel plausibility core
// Per-channel open/short detection and rate-of-change plausibility of
// converted temperature samples, with a latched rate fault.
// ----------------------------------------------------------------------------
// Usage
// Samples arrive on the input channel (i_in_valid / o_in_stall) as one
// transaction each: channel index, raw ADC code, converted temperature and a
// millisecond timestamp. Every sample produces exactly one result transaction
// on the output channel (o_out_valid / i_out_stall) carrying the channel, its
// fault code, whether the held reading is valid and the held temperature.
// The sample is captured in an input register; the channel state is then
// read, checked and written back while the result register loads, and one
// transaction is accepted every cycle while the receiver does not stall. The
// per-channel read-modify-write completes as the result register loads, so
// samples of the same channel may follow back to back. When the receiver
// stalls, the result register holds and one further sample is still taken
// into the input register; after that o_in_stall is raised until the result is taken.
// Reset clears the channel state (fault OK, not primed, not valid, zero held
// value and time) and loads the threshold and rate-limit defaults.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_channel_plausibility_core #(
    parameter int CHANNELS     = 8,
    parameter int REJECT_LIMIT = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [tcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [2:0]                     i_channel,
    input  wire logic [11:0]                    i_adc_code,
    input  wire logic signed [15:0]             i_temperature,
    input  wire logic [31:0]                    i_time_ms,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [2:0]                          o_out_channel,
    output logic [1:0]                          o_fault_code,
    output logic                                o_reading_valid,
    output logic signed [15:0]                  o_held_temperature
);
    import tcp_pkg::*;

    localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RcW = $clog2(REJECT_LIMIT + 1);

    t_cfg        cfg;

    // Pipeline control
    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;
    logic        in_accept;
    logic        s2_load;

    // Channel state, one entry per channel
    t_chan_state r_state [CHANNELS];
    logic [RcW-1:0] r_rej_cnt [CHANNELS];

    logic [6:0]     ch_ext;
    logic           in_range;
    logic [ChW-1:0] idx;
    t_chan_state    cur_state;
    logic [RcW-1:0] cur_rej_cnt;
    t_chan_state    n_state;
    logic [RcW-1:0] n_rej_cnt;
    t_result        eval_result;
    t_result        n_result;

    tcp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The result register loads the captured sample whenever it is empty or being drained.
    assign s2_load    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s2_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s2_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.channel     <= i_channel;
            r_item.adc_code    <= i_adc_code;
            r_item.temperature <= i_temperature;
            r_item.time_ms     <= i_time_ms;
        end
    end

    // Channel lookup. Indexes at or beyond CHANNELS touch no state and report
    // a clean, invalid, zero result.
    assign ch_ext   = {4'd0, r_item.channel};
    assign in_range = ch_ext < 7'(CHANNELS);
    assign idx      = ch_ext[ChW-1:0];

    always_comb begin
        cur_state   = '0;
        cur_rej_cnt = '0;
        if (in_range) begin
            cur_state   = r_state[idx];
            cur_rej_cnt = r_rej_cnt[idx];
        end
    end

    tcp_eval #(
        .REJECT_LIMIT (REJECT_LIMIT)
    ) u_eval (
        .i_cfg     (cfg),
        .i_item    (r_item),
        .i_state   (cur_state),
        .i_rej_cnt (cur_rej_cnt),
        .o_state   (n_state),
        .o_rej_cnt (n_rej_cnt),
        .o_result  (eval_result)
    );

    always_comb begin
        n_result = eval_result;
        if (!in_range) begin
            n_result.fault_code       = FAULT_OK;
            n_result.reading_valid    = 1'b0;
            n_result.held_temperature = '0;
        end
    end

    // Write-back of the channel state in the same cycle as the result loads,
    // so the next sample of the same channel already sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_state[i]   <= '0;
                r_rej_cnt[i] <= '0;
            end
        end else if (s2_load && in_range) begin
            r_state[idx]   <= n_state;
            r_rej_cnt[idx] <= n_rej_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_channel      = r_result.out_channel;
    assign o_fault_code       = r_result.fault_code;
    assign o_reading_valid    = r_result.reading_valid;
    assign o_held_temperature = r_result.held_temperature;

    // A valid reading is never reported together with a fault.
    a_valid_means_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_valid) |-> (o_fault_code == FAULT_OK))
        else $error("valid reading reported with a fault");

    // A channel outside the store reports a clean, invalid, zero result.
    a_out_of_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ({4'd0, o_out_channel} >= 7'(CHANNELS)))
        |-> (o_fault_code == FAULT_OK && !o_reading_valid && o_held_temperature == '0))
        else $error("out-of-range channel produced a non-zero result");

    // Upstream is only held off while both stages are occupied.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A sample taken in reaches the result register once it can move.
    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> o_out_valid)
        else $error("captured sample did not advance to the result register");

endmodule

`default_nettype wire
